/* hdl/bounded_id_set_table_core_macros.svh */
// Assertion macros for the bounded id set table.
// Used by bounded_id_set_table_core; expects clk and rst_n in scope.
`ifndef BOUNDED_ID_SET_TABLE_CORE_MACROS_SVH
`define BOUNDED_ID_SET_TABLE_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define BIDST_ASSERT_NOW(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define BIDST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/bidst_pkg.sv */
// Shared constants and types for the bounded id set table.
// No dependencies.
package bidst_pkg;

  localparam int CAPACITY = 16;
  localparam int ID_BITS  = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_DEL  = 2'd1,
    OP_FIND = 2'd2,
    OP_READ = 2'd3
  } op_t;

endpackage

/* hdl/bidst_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bidst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/bounded_id_set_table_core.sv */
// Bounded id set table: insertion-ordered set of distinct ids with a held count.
// Depends on bidst_pkg, bidst_ram and bounded_id_set_table_core_macros.svh.
//
// Usage:
//   Input channel: an operation (add, delete, find, read at position) is taken
//   at a rising edge where start is high and busy is low. Operands in_op, in_id
//   and in_position are sampled at that edge only.
//   Result channel: each operation gives exactly one result beat, held on the
//   out_ ports for one cycle with out_valid high. The receiver cannot stall;
//   it must take the beat in that cycle. busy drops in the strobe cycle, so the
//   next operation may be started while the result is on the ports.
//   Config: cfg_wr_en/cfg_wr_data write the reserved id; write only while idle.
// Path from accept to strobe:
//   reserved id operand, full add, out-of-range read: answered from idle.
//   read in range: through S_READ and S_RDATA, then the registered beat.
//   add/find/delete: a walk over the held entries in S_SCAN, one entry per
//   cycle through the entry RAM read port; a delete that hits at position w
//   then shifts the later entries down in S_SHIFT, taking longer than a find.
// Worst case: a delete that hits a full set before its last entry, e.g. the head.
// Reset: synchronous, active low. The count clears and the reserved id returns
// to all ones. The entry RAM is not cleared: only held entries are ever read.
module bounded_id_set_table_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           start,
  output logic                           busy,
  input  bidst_pkg::op_t                 in_op,
  input  logic [bidst_pkg::ID_BITS-1:0]  in_id,
  input  logic [bidst_pkg::IDX_W-1:0]    in_position,
  // config
  input  logic                           cfg_wr_en,
  input  logic [bidst_pkg::ID_BITS-1:0]  cfg_wr_data,
  // result channel
  output logic                           out_valid,
  output logic                           out_status,
  output logic                           out_found,
  output logic [bidst_pkg::IDX_W-1:0]    out_index_out,
  output logic [bidst_pkg::ID_BITS-1:0]  out_id_out,
  output logic [bidst_pkg::CNT_W-1:0]    out_count_out
);

  import bidst_pkg::*;

`include "bounded_id_set_table_core_macros.svh"

  // S_SCAN: search held entries; S_SHIFT: delete compaction;
  // S_READ/S_RDATA: read at position through the RAM port.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_READ,
    S_RDATA
  } state_t;

  state_t               state_r, state_nxt;
  op_t                  op_r, op_nxt;
  logic [ID_BITS-1:0]   id_r, id_nxt;
  logic [IDX_W-1:0]     pos_r, pos_nxt;
  logic [ID_BITS-1:0]   reserved_r, reserved_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  // scan: next address to issue, and the compare pending on RAM data
  logic [CNT_W-1:0]     iss_r, iss_nxt;
  logic                 cmp_v_r, cmp_v_nxt;
  logic [IDX_W-1:0]     cmp_idx_r, cmp_idx_nxt;
  // shift: next source to read, and the write pending on RAM data
  logic [CNT_W-1:0]     src_r, src_nxt;
  logic                 wv_r, wv_nxt;
  logic [IDX_W-1:0]     waddr_r, waddr_nxt;
  // registered result beat
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_status_r, out_status_nxt;
  logic                 out_found_r, out_found_nxt;
  logic [IDX_W-1:0]     out_index_r, out_index_nxt;
  logic [ID_BITS-1:0]   out_id_r, out_id_nxt;

  // entry RAM port
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ID_BITS-1:0]   ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [ID_BITS-1:0]   ram_rdata;
  logic                 hit;

  bidst_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign hit = cmp_v_r && (ram_rdata == id_r);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    id_nxt         = id_r;
    pos_nxt        = pos_r;
    reserved_nxt   = reserved_r;
    count_nxt      = count_r;
    iss_nxt        = iss_r;
    cmp_v_nxt      = cmp_v_r;
    cmp_idx_nxt    = cmp_idx_r;
    src_nxt        = src_r;
    wv_nxt         = wv_r;
    waddr_nxt      = waddr_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = 1'b0;
    out_found_nxt  = 1'b0;
    out_index_nxt  = '0;
    out_id_nxt     = '0;
    ram_we         = 1'b0;
    ram_waddr      = waddr_r;
    ram_wdata      = id_r;
    ram_raddr      = iss_r[IDX_W-1:0];

    if (cfg_wr_en) begin
      reserved_nxt = cfg_wr_data;
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_op;
          id_nxt    = in_id;
          pos_nxt   = in_position;
          iss_nxt   = '0;
          cmp_v_nxt = 1'b0;
          if (in_op == OP_READ) begin
            if ({1'b0, in_position} >= count_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = 1'b1;
              out_id_nxt     = reserved_r;
            end else begin
              state_nxt = S_READ;
            end
          end else if (in_id == reserved_r ||
                       (in_op == OP_ADD && count_r == CNT_W'(CAPACITY))) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = 1'b1;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (hit) begin
          case (op_r)
            OP_DEL: begin
              src_nxt   = {1'b0, cmp_idx_r} + CNT_W'(1);
              wv_nxt    = 1'b0;
              state_nxt = S_SHIFT;
            end
            OP_FIND: begin
              out_valid_nxt = 1'b1;
              out_found_nxt = 1'b1;
              out_index_nxt = cmp_idx_r;
              state_nxt     = S_IDLE;
            end
            default: begin
              // duplicate add: accepted, nothing changes
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          endcase
        end else if (iss_r < count_r) begin
          ram_raddr   = iss_r[IDX_W-1:0];
          cmp_v_nxt   = 1'b1;
          cmp_idx_nxt = iss_r[IDX_W-1:0];
          iss_nxt     = iss_r + CNT_W'(1);
        end else begin
          // walked all held entries without a match
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (op_r == OP_ADD) begin
            ram_we    = 1'b1;
            ram_waddr = count_r[IDX_W-1:0];
            ram_wdata = id_r;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            out_status_nxt = 1'b1;
          end
        end
      end

      S_SHIFT: begin
        // entry[i] <= entry[i+1], one read and one write per cycle
        if (wv_r) begin
          ram_we    = 1'b1;
          ram_waddr = waddr_r;
          ram_wdata = ram_rdata;
        end
        if (src_r < count_r) begin
          ram_raddr = src_r[IDX_W-1:0];
          wv_nxt    = 1'b1;
          waddr_nxt = src_r[IDX_W-1:0] - IDX_W'(1);
          src_nxt   = src_r + CNT_W'(1);
        end else begin
          wv_nxt = 1'b0;
          if (!wv_r) begin
            count_nxt     = count_r - CNT_W'(1);
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end

      S_READ: begin
        ram_raddr = pos_r;
        state_nxt = S_RDATA;
      end

      S_RDATA: begin
        out_valid_nxt = 1'b1;
        out_id_nxt    = ram_rdata;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      reserved_r  <= '1;
      count_r     <= '0;
      cmp_v_r     <= 1'b0;
      wv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      reserved_r  <= reserved_nxt;
      count_r     <= count_nxt;
      cmp_v_r     <= cmp_v_nxt;
      wv_r        <= wv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    pos_r        <= pos_nxt;
    iss_r        <= iss_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    src_r        <= src_nxt;
    waddr_r      <= waddr_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_index_r  <= out_index_nxt;
    out_id_r     <= out_id_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_found     = out_found_r;
  assign out_index_out = out_index_r;
  assign out_id_out    = out_id_r;
  assign out_count_out = count_r;

  // count never passes capacity
  `BIDST_ASSERT_NOW(a_count_bound, count_r <= CNT_W'(CAPACITY), "held count above capacity")
  // a result beat always leaves the block ready for the next request
  `BIDST_ASSERT_NOW(a_strobe_idle, !out_valid_r || !busy, "result strobe while busy")
  // an accepted request either finishes at once or keeps the block busy
  `BIDST_ASSERT_NEXT(a_accept_progress, start && !busy, busy || out_valid_r, "request lost")
  // entry RAM is only written while an operation is in flight
  `BIDST_ASSERT_NOW(a_write_busy, !ram_we || busy, "entry write while idle")
  // count moves only together with a result beat
  `BIDST_ASSERT_NOW(a_count_with_beat, count_r == $past(count_r) || out_valid_r, "count moved")

endmodule
